// File: rtl/vagg_pkg.sv
// Shared types and constants for the vote aggregator.
package vagg_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_VOTE_MODE     = 2'd0;
    localparam logic [1:0] CFG_DEFAULT_VALUE = 2'd1;
    localparam logic [1:0] CFG_FORCE_ENABLE  = 2'd2;
    localparam logic [1:0] CFG_FORCE_VALUE   = 2'd3;

    // Election rules
    typedef enum logic [1:0] {
        MODE_MIN = 2'd0,
        MODE_MAX = 2'd1,
        MODE_OR  = 2'd2,
        MODE_AND = 2'd3
    } t_mode;

    // Where the reported value came from
    typedef enum logic [1:0] {
        SRC_DEFAULT  = 2'd0,
        SRC_CLIENT   = 2'd1,
        SRC_OVERRIDE = 2'd2,
        SRC_FORCE    = 2'd3
    } t_source;

    // Request kinds
    localparam logic REQ_VOTE     = 1'b0;
    localparam logic REQ_OVERRIDE = 1'b1;

    // Input request
    typedef struct packed {
        logic               req_type;
        logic [4:0]         client_index;
        logic               vote_enable;
        logic signed [31:0] vote_value;
    } t_vote_req;

    // Result
    typedef struct packed {
        logic signed [31:0] effective_value;
        logic [1:0]         effective_source;
        logic [4:0]         winner_slot;
        logic               notify;
        logic signed [31:0] notify_value;
        logic               ignored;
    } t_vote_res;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_CHECK,
        ST_SCAN,
        ST_ELECT,
        ST_DONE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic ovr_apply;
        logic rd_req;
        logic vote_write;
        logic scan_start;
        logic scan_step;
        logic elect_commit;
        logic out_load;
    } t_ctrl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic is_ovr;
        logic in_range;
        logic ignore;
        logic scan_done;
        logic out_free;
    } t_dp_status;

endpackage

// File: rtl/vagg_ctrl.sv
// Request sequencer of the vote aggregator.
module vagg_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  vagg_pkg::t_dp_status i_stat,
    output vagg_pkg::t_ctrl_cmd  o_cmd
);
    import vagg_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (i_stat.is_ovr || !i_stat.in_range) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_state = i_stat.ignore ? ST_DONE : ST_SCAN;
            end
            ST_SCAN: begin
                if (i_stat.scan_done) begin
                    n_state = ST_ELECT;
                end
            end
            ST_ELECT: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Commands
    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            ST_DISPATCH: begin
                o_cmd.ovr_apply = i_stat.is_ovr;
                o_cmd.rd_req    = !i_stat.is_ovr && i_stat.in_range;
            end
            ST_CHECK: begin
                o_cmd.vote_write = 1'b1;
                o_cmd.scan_start = !i_stat.ignore;
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
            end
            ST_ELECT: begin
                o_cmd.elect_commit = 1'b1;
            end
            ST_DONE: begin
                o_cmd.out_load = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// File: rtl/vagg_dp.sv
// Vote store, election scan, override and result datapath.
module vagg_dp #(
    parameter int SLOT_COUNT = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  vagg_pkg::t_vote_req  i_req,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_addr,
    input  logic [31:0]          i_cfg_wdata,
    input  vagg_pkg::t_ctrl_cmd  i_cmd,
    output vagg_pkg::t_dp_status o_stat,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output vagg_pkg::t_vote_res  o_out_data
);
    import vagg_pkg::*;

    localparam int IW   = $clog2(SLOT_COUNT);
    localparam int CNTW = $clog2(SLOT_COUNT + 1);

    // Configuration
    t_mode              r_mode;
    logic signed [31:0] r_default;
    logic               r_force_en;
    logic [31:0]        r_force_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_MIN;
            r_default   <= '0;
            r_force_en  <= 1'b0;
            r_force_val <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_VOTE_MODE:     r_mode      <= t_mode'(i_cfg_wdata[1:0]);
                CFG_DEFAULT_VALUE: r_default   <= i_cfg_wdata;
                CFG_FORCE_ENABLE:  r_force_en  <= i_cfg_wdata[0];
                CFG_FORCE_VALUE:   r_force_val <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Latched request
    t_vote_req r_req;
    logic [IW-1:0] req_slot;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
    end

    assign req_slot = IW'(r_req.client_index);

    // Vote store: {enable, value} per slot; a slot never written reads as zero
    logic [32:0]            r_mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0]  r_mvalid;
    logic [32:0]            r_rdata;
    logic                   r_rd_ok;
    logic [CNTW-1:0]        r_scan_cnt;
    logic                   rd_en;
    logic [IW-1:0]          rd_addr;
    logic                   scan_issue;

    assign scan_issue = i_cmd.scan_step && (r_scan_cnt < CNTW'(SLOT_COUNT));
    assign rd_en      = i_cmd.rd_req || scan_issue;
    assign rd_addr    = i_cmd.rd_req ? req_slot : r_scan_cnt[IW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.vote_write) begin
            r_mem[req_slot] <= {r_req.vote_enable, r_req.vote_value};
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvalid <= '0;
            r_rd_ok  <= 1'b0;
        end else begin
            if (i_cmd.vote_write) begin
                r_mvalid[req_slot] <= 1'b1;
            end
            if (rd_en) begin
                r_rd_ok <= r_mvalid[rd_addr];
            end
        end
    end

    // Repeat detection against the stored slot
    logic               rd_en_bit;
    logic signed [31:0] rd_val;
    logic               r_any_seen;
    logic               similar;

    assign rd_en_bit = r_rd_ok & r_rdata[32];
    assign rd_val    = r_rd_ok ? r_rdata[31:0] : '0;
    assign similar   = (rd_en_bit == r_req.vote_enable) && (rd_val == r_req.vote_value);

    // Election scan: one slot compared per cycle, in the cycle after its read
    logic               r_cmp_vld;
    logic [IW-1:0]      r_cmp_idx;
    logic signed [31:0] r_res;
    logic [IW-1:0]      r_who;
    logic               r_found;
    logic               r_stop;
    logic               take;
    logic               better;
    logic               halt;

    always_comb begin
        better = (r_mode == MODE_MIN) ? (rd_val < r_res) : (rd_val > r_res);
        halt   = (r_mode == MODE_OR) ? (rd_val != '0) : (rd_val == '0);
        take   = r_cmp_vld && rd_en_bit && !r_stop;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_cnt <= '0;
            r_cmp_vld  <= 1'b0;
            r_found    <= 1'b0;
            r_stop     <= 1'b0;
        end else if (i_cmd.scan_start) begin
            r_scan_cnt <= '0;
            r_cmp_vld  <= 1'b0;
            r_found    <= 1'b0;
            r_stop     <= 1'b0;
        end else if (i_cmd.scan_step) begin
            r_cmp_vld <= scan_issue;
            if (scan_issue) begin
                r_scan_cnt <= r_scan_cnt + CNTW'(1);
            end
            if (take) begin
                r_found <= 1'b1;
                if (r_mode == MODE_OR || r_mode == MODE_AND) begin
                    r_stop <= halt;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_step) begin
            if (scan_issue) begin
                r_cmp_idx <= r_scan_cnt[IW-1:0];
            end
            if (take) begin
                if (r_mode == MODE_OR || r_mode == MODE_AND || !r_found || better) begin
                    r_res <= rd_val;
                    r_who <= r_cmp_idx;
                end
            end
        end
    end

    // Election outcome and commit
    logic signed [31:0] r_elect_val;
    logic               r_elect_none;
    logic [IW-1:0]      r_elect_idx;
    logic signed [31:0] n_res;
    logic               n_none;
    logic [IW-1:0]      n_who;
    logic               changed;
    logic               r_ovr_active;
    logic signed [31:0] r_ovr_val;
    logic [4:0]         r_ovr_tag;
    logic signed [31:0] stored;

    always_comb begin
        n_none  = !r_found;
        n_res   = r_found ? r_res : r_default;
        n_who   = '0;
        if (r_found) begin
            n_who = (r_mode == MODE_OR || r_mode == MODE_AND) ? req_slot : r_who;
        end
        changed = !r_any_seen || (n_res != r_elect_val) || (n_none != r_elect_none)
                  || (n_who != r_elect_idx);
        stored  = r_any_seen ? r_elect_val : ((r_mode == MODE_OR) ? '0 : r_default);
    end

    // Per-request flags
    logic               r_notify;
    logic signed [31:0] r_nval;
    logic               r_ignored;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_any_seen   <= 1'b0;
            r_elect_val  <= '0;
            r_elect_none <= 1'b1;
            r_elect_idx  <= '0;
            r_ovr_active <= 1'b0;
            r_ovr_val    <= '0;
            r_ovr_tag    <= '0;
            r_notify     <= 1'b0;
            r_nval       <= '0;
            r_ignored    <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_notify  <= 1'b0;
                r_nval    <= '0;
                r_ignored <= 1'b0;
            end
            // Override set or clear
            if (i_cmd.ovr_apply) begin
                if (r_force_en) begin
                    r_ovr_active <= r_req.vote_enable;
                    r_ovr_val    <= r_req.vote_value;
                end else if (r_req.vote_enable) begin
                    r_notify     <= 1'b1;
                    r_nval       <= r_req.vote_value;
                    r_ovr_active <= 1'b1;
                    r_ovr_val    <= r_req.vote_value;
                    r_ovr_tag    <= r_req.client_index;
                end else begin
                    r_notify     <= 1'b1;
                    r_nval       <= stored;
                    r_ovr_active <= 1'b0;
                end
            end
            // Identical repeat after the first vote
            if (i_cmd.vote_write && similar && r_any_seen) begin
                r_ignored <= 1'b1;
            end
            if (i_cmd.elect_commit) begin
                if (changed) begin
                    r_elect_val  <= n_res;
                    r_elect_none <= n_none;
                    r_elect_idx  <= n_who;
                    if (!r_force_en && !r_ovr_active) begin
                        r_notify <= 1'b1;
                        r_nval   <= n_res;
                    end
                end
                r_any_seen <= 1'b1;
            end
        end
    end

    // Result assembly
    t_vote_res res_next;

    always_comb begin
        res_next              = '0;
        res_next.notify       = r_notify;
        res_next.notify_value = r_nval;
        res_next.ignored      = r_ignored;
        if (r_force_en) begin
            res_next.effective_value  = r_force_val;
            res_next.effective_source = SRC_FORCE;
        end else if (r_ovr_active) begin
            res_next.effective_value  = r_ovr_val;
            res_next.effective_source = SRC_OVERRIDE;
            res_next.winner_slot      = r_ovr_tag;
        end else if (r_any_seen && !r_elect_none) begin
            res_next.effective_value  = r_elect_val;
            res_next.effective_source = SRC_CLIENT;
            res_next.winner_slot      = 5'(r_elect_idx);
        end else begin
            res_next.effective_value  = stored;
            res_next.effective_source = SRC_DEFAULT;
        end
    end

    // Output register
    logic      r_out_valid;
    t_vote_res r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out <= res_next;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Status
    always_comb begin
        o_stat           = '0;
        o_stat.is_ovr    = (r_req.req_type == REQ_OVERRIDE);
        o_stat.in_range  = 32'(r_req.client_index) < 32'(SLOT_COUNT);
        o_stat.ignore    = similar && r_any_seen;
        o_stat.scan_done = (r_scan_cnt == CNTW'(SLOT_COUNT));
        o_stat.out_free  = !r_out_valid || !i_out_stall;
    end

    // Checks
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scan_cnt <= CNTW'(SLOT_COUNT))
        else $error("scan counter past last slot");

    a_none_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_elect_none |-> (r_elect_idx == '0))
        else $error("no winner but slot index set");

    a_commit_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.elect_commit |=> r_any_seen)
        else $error("election commit did not mark a vote seen");

endmodule

// File: rtl/vote_aggregator_unit.sv
// Top level of the vote aggregator: sequencer plus datapath.
// Resolves one signed value from per-slot client votes (min, max, first-nonzero
// or first-zero election), an override and a debug force, one request at a
// time. A client vote that runs the election is held up by the election scan,
// which reads one slot per cycle from the vote store; an ignored repeat, an
// override or an out-of-range slot skips the scan. A finished result waits
// in an output register while the next request is accepted.
module vote_aggregator_unit #(
    parameter int SLOT_COUNT = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  vagg_pkg::t_vote_req i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output vagg_pkg::t_vote_res o_out_data,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_addr,
    input  logic [31:0]         i_cfg_wdata
);
    import vagg_pkg::*;

    t_ctrl_cmd  cmd;
    t_dp_status stat;

    vagg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    vagg_dp #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // Checks
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second request accepted while one is in progress");

    a_ignore_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.ignored) |-> !o_out_data.notify)
        else $error("ignored repeat raised a notification");

    a_nval_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.notify) |-> (o_out_data.notify_value == '0))
        else $error("notify value without notification");

    a_force_client: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.effective_source == SRC_FORCE
            || o_out_data.effective_source == SRC_DEFAULT))
        |-> (o_out_data.winner_slot == '0))
        else $error("client reported for forced or default result");

endmodule

// File: test/tb_top.sv
// Self-checking testbench for vote_aggregator_unit with its own vote-resolution model.
`timescale 1ns / 100ps

module tb_top;
    import vagg_pkg::*;

    localparam int          NUM_SLOTS  = 32;
    localparam int          NO_WINNER  = 64;
    localparam logic [31:0] INT_MIN_V  = 32'h8000_0000;
    localparam logic [31:0] INT_MAX_V  = 32'h7fff_ffff;
    localparam int          RAND_PHASE = 75;

    // Clock, reset and DUT ports
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        o_in_stall;
    t_vote_req   in_data = '0;
    logic        o_out_valid;
    logic        out_stall = 1'b0;
    t_vote_res   o_out_data;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [31:0] cfg_wdata = '0;

    vote_aggregator_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Request queue, expected results, bookkeeping
    t_vote_req   vote_reqs[$];
    t_vote_res   awaited_results[$];
    int          n_queued = 0;
    int          n_taken = 0;
    int          n_fail = 0;
    int          n_votes = 0;
    int          n_overrides = 0;
    int          n_notify = 0;
    int          n_dropped = 0;
    bit          calm = 1'b0;

    // Last vote queued per slot, used to build identical repeats
    logic        sent_en [NUM_SLOTS];
    logic [31:0] sent_val [NUM_SLOTS];

    // Model registers and state
    t_mode       mdl_mode = MODE_MIN;
    logic [31:0] mdl_default = '0;
    logic        mdl_force = 1'b0;
    logic [31:0] mdl_force_val = '0;
    logic        slot_en [NUM_SLOTS];
    logic [31:0] slot_val [NUM_SLOTS];
    bit          seen_vote = 1'b0;
    logic [31:0] elect_val = '0;
    int          elect_who = NO_WINNER;
    bit          ovr_on = 1'b0;
    logic [31:0] ovr_val = '0;
    logic [4:0]  ovr_tag = '0;

    initial begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_en[i]  = 1'b0;
            slot_val[i] = '0;
            sent_en[i]  = 1'b0;
            sent_val[i] = '0;
        end
    end

    // Random idle decision, off during the calm phase
    function automatic bit idle_now();
        return !calm && ($urandom_range(99) < 25);
    endfunction

    // Stored election; before any vote it reads 0 in OR mode, else the default
    function automatic logic [31:0] held_value();
        if (!seen_vote)
            return (mdl_mode == MODE_OR) ? 32'd0 : mdl_default;
        return elect_val;
    endfunction

    // Model of one request: update state, return the result it produces
    function automatic t_vote_res resolve_vote(t_vote_req rq);
        t_vote_res   r;
        logic [31:0] best;
        int          who;
        int          idx;
        bit          found;
        bit          similar;
        r = '0;
        if (rq.req_type == REQ_OVERRIDE) begin
            n_overrides++;
            if (mdl_force) begin
                // forced: tag kept, no notify
                ovr_on  = rq.vote_enable;
                ovr_val = rq.vote_value;
            end else if (rq.vote_enable) begin
                r.notify       = 1'b1;
                r.notify_value = rq.vote_value;
                ovr_on         = 1'b1;
                ovr_val        = rq.vote_value;
                ovr_tag        = rq.client_index;
            end else begin
                r.notify       = 1'b1;
                r.notify_value = held_value();
                ovr_on         = 1'b0;
            end
        end else begin
            n_votes++;
            idx = int'(rq.client_index);
            similar = (slot_en[idx] == rq.vote_enable) && (slot_val[idx] == rq.vote_value);
            slot_en[idx]  = rq.vote_enable;
            slot_val[idx] = rq.vote_value;
            if (similar && seen_vote) begin
                r.ignored = 1'b1;
            end else begin
                found = 1'b0;
                best  = '0;
                who   = NO_WINNER;
                // election scan in slot order
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (!slot_en[i])
                        continue;
                    if (mdl_mode == MODE_MIN || mdl_mode == MODE_MAX) begin
                        if (!found || ((mdl_mode == MODE_MIN) ?
                                ($signed(slot_val[i]) < $signed(best)) :
                                ($signed(slot_val[i]) > $signed(best)))) begin
                            best  = slot_val[i];
                            who   = i;
                            found = 1'b1;
                        end
                    end else begin
                        best  = slot_val[i];
                        who   = idx;
                        found = 1'b1;
                        if ((mdl_mode == MODE_OR) ? (slot_val[i] != 0) : (slot_val[i] == 0))
                            break;
                    end
                end
                if (!found) begin
                    best = mdl_default;
                    who  = NO_WINNER;
                end
                if (!seen_vote || best != elect_val || who != elect_who) begin
                    elect_val = best;
                    elect_who = who;
                    if (!mdl_force && !ovr_on) begin
                        r.notify       = 1'b1;
                        r.notify_value = best;
                    end
                end
                seen_vote = 1'b1;
            end
        end

        // precedence: force, override, election, default
        if (mdl_force) begin
            r.effective_value  = mdl_force_val;
            r.effective_source = SRC_FORCE;
        end else if (ovr_on) begin
            r.effective_value  = ovr_val;
            r.effective_source = SRC_OVERRIDE;
            r.winner_slot      = ovr_tag;
        end else if (seen_vote && elect_who != NO_WINNER) begin
            r.effective_value  = elect_val;
            r.effective_source = SRC_CLIENT;
            r.winner_slot      = elect_who[4:0];
        end else begin
            r.effective_value  = held_value();
            r.effective_source = SRC_DEFAULT;
        end
        return r;
    endfunction

    // Request driver
    always @(posedge i_clk) begin : drive_proc
        t_vote_req nxt_data;
        logic      nxt_valid;
        nxt_data  = in_data;
        nxt_valid = in_valid;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
        end else begin
            if (in_valid && !o_in_stall) begin
                awaited_results.push_back(resolve_vote(in_data));
                n_taken++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid && vote_reqs.size() > 0 && !idle_now()) begin
                nxt_data  = vote_reqs.pop_front();
                nxt_valid = 1'b1;
            end
        end
        in_valid <= nxt_valid;
        in_data  <= nxt_data;
    end

    task automatic log_fail(string what, t_vote_res got, t_vote_res want);
        n_fail++;
        if (n_fail <= 10) begin
            $display("%0t %s", $realtime, what);
            $display("  got : value %h src %0d client %0d notify %0b nval %h ign %0b",
                     got.effective_value, got.effective_source, got.winner_slot,
                     got.notify, got.notify_value, got.ignored);
            $display("  want: value %h src %0d client %0d notify %0b nval %h ign %0b",
                     want.effective_value, want.effective_source, want.winner_slot,
                     want.notify, want.notify_value, want.ignored);
        end
    endtask

    // Result monitor
    always @(posedge i_clk) begin : watch_proc
        t_vote_res want;
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (awaited_results.size() == 0) begin
                log_fail("result with nothing outstanding", o_out_data, '0);
            end else begin
                want = awaited_results.pop_front();
                n_notify  += want.notify;
                n_dropped += want.ignored;
                if (o_out_data !== want)
                    log_fail("result differs", o_out_data, want);
            end
        end
        out_stall <= idle_now();
    end

    task automatic add_item(logic rtype, logic [4:0] idx, logic en, logic [31:0] val);
        t_vote_req rq;
        rq.req_type     = rtype;
        rq.client_index = idx;
        rq.vote_enable  = en;
        rq.vote_value   = val;
        if (rtype == REQ_VOTE) begin
            sent_en[idx]  = en;
            sent_val[idx] = val;
        end
        vote_reqs.push_back(rq);
        n_queued++;
    endtask

    // Write one register; the model follows at once since the block is idle
    task automatic write_reg(logic [1:0] addr, logic [31:0] data);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        case (addr)
            CFG_VOTE_MODE:     mdl_mode = t_mode'(data[1:0]);
            CFG_DEFAULT_VALUE: mdl_default = data;
            CFG_FORCE_ENABLE:  mdl_force = data[0];
            CFG_FORCE_VALUE:   mdl_force_val = data;
            default: ;
        endcase
    endtask

    task automatic set_config(t_mode mode, logic [31:0] dflt, logic fen, logic [31:0] fval);
        write_reg(CFG_VOTE_MODE, {30'd0, mode});
        write_reg(CFG_DEFAULT_VALUE, dflt);
        write_reg(CFG_FORCE_ENABLE, {31'd0, fen});
        write_reg(CFG_FORCE_VALUE, fval);
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Wait until every queued request is accepted and answered, then settle
    task automatic drain();
        while (n_taken != n_queued || awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(6))
            0: return 32'd0;
            1: return 32'd1;
            2: return 32'hffff_ffff;
            3: return INT_MIN_V;
            4: return INT_MAX_V;
            5: return $urandom_range(16) - 8;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [4:0] pick_slot();
        return ($urandom_range(99) < 70) ? 5'($urandom_range(7)) : 5'($urandom_range(31));
    endfunction

    // Mostly votes on a few busy slots, some exact repeats, some overrides
    task automatic add_random_items(int count);
        int          roll;
        logic [4:0]  idx;
        for (int k = 0; k < count; k++) begin
            roll = $urandom_range(99);
            if (roll < 10) begin
                add_item(REQ_OVERRIDE, 5'($urandom_range(31)), $urandom_range(99) < 60,
                         pick_value());
            end else if (roll < 30) begin
                idx = pick_slot();
                add_item(REQ_VOTE, idx, sent_en[idx], sent_val[idx]);
            end else begin
                add_item(REQ_VOTE, pick_slot(), $urandom_range(99) < 75, pick_value());
            end
        end
    endtask

    function automatic logic [31:0] pick_default();
        case ($urandom_range(3))
            0: return INT_MIN_V;
            1: return INT_MAX_V;
            2: return 32'd0;
            default: return $urandom;
        endcase
    endfunction

    // Stimulus sequence
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // before any vote, OR mode: override set then clear reads back 0
        set_config(MODE_OR, INT_MIN_V, 1'b0, 32'hffff_ffff);
        add_item(REQ_OVERRIDE, 5'd31, 1'b1, INT_MAX_V);
        add_item(REQ_OVERRIDE, 5'd0, 1'b0, 32'd0);
        drain();

        // before any vote, MIN mode: clear reads back the default
        set_config(MODE_MIN, INT_MAX_V, 1'b0, 32'hffff_ffff);
        add_item(REQ_OVERRIDE, 5'd0, 1'b0, 32'd0);
        drain();

        // forced: override changes quietly, first vote equal to reset state
        set_config(MODE_MIN, INT_MAX_V, 1'b1, 32'd0);
        add_item(REQ_OVERRIDE, 5'd5, 1'b1, 32'hffff_ffff);
        add_item(REQ_VOTE, 5'd0, 1'b0, 32'd0);
        add_item(REQ_OVERRIDE, 5'd9, 1'b0, 32'd3);
        drain();

        // MIN: extremes, repeat, tie to lowest slot, override over election
        set_config(MODE_MIN, INT_MAX_V, 1'b0, 32'd0);
        add_item(REQ_VOTE, 5'd31, 1'b1, INT_MAX_V);
        add_item(REQ_VOTE, 5'd1, 1'b1, INT_MIN_V);
        add_item(REQ_VOTE, 5'd1, 1'b1, INT_MIN_V);
        add_item(REQ_VOTE, 5'd2, 1'b1, INT_MIN_V);
        add_item(REQ_VOTE, 5'd1, 1'b0, INT_MIN_V);
        add_item(REQ_OVERRIDE, 5'd17, 1'b1, 32'h1234_5678);
        add_item(REQ_VOTE, 5'd3, 1'b1, 32'hffff_fffb);
        add_item(REQ_OVERRIDE, 5'd17, 1'b0, 32'd0);
        drain();

        // MAX: top vote, an identical repeat, then a lower vote
        set_config(MODE_MAX, INT_MIN_V, 1'b0, 32'd0);
        add_item(REQ_VOTE, 5'd4, 1'b1, INT_MAX_V);
        add_item(REQ_VOTE, 5'd4, 1'b1, INT_MAX_V);
        add_item(REQ_VOTE, 5'd0, 1'b1, 32'd0);
        drain();

        // AND stops at the first zero, OR at the first nonzero
        set_config(MODE_AND, 32'd0, 1'b0, 32'd0);
        add_item(REQ_VOTE, 5'd5, 1'b1, 32'd0);
        add_item(REQ_VOTE, 5'd5, 1'b1, 32'd1);
        drain();
        set_config(MODE_OR, 32'd0, 1'b0, 32'd0);
        add_item(REQ_VOTE, 5'd6, 1'b1, 32'd0);
        add_item(REQ_VOTE, 5'd0, 1'b1, 32'd1);
        add_item(REQ_VOTE, 5'd0, 1'b0, 32'd1);
        drain();

        // Random phases over all modes; one forced, one without any idling
        for (int p = 0; p < 8; p++) begin
            set_config(t_mode'(p % 4), pick_default(), p == 5,
                       (p == 5) ? $urandom : 32'd0);
            calm = (p == 2);
            add_random_items(RAND_PHASE);
            drain();
        end
        calm = 1'b0;

        repeat (60) @(posedge i_clk);
        n_fail += awaited_results.size();
        $display("Ran %0d requests: %0d votes, %0d overrides, in min/max/or/and modes",
                 n_taken, n_votes, n_overrides);
        $display("with force and override; %0d notifications, %0d repeats dropped",
                 n_notify, n_dropped);
        if (n_fail == 0) begin
            $display("vote_aggregator_unit: match");
        end else begin
            $display("vote_aggregator_unit: mismatch");
        end
        $finish;
    end

    // Run limit
    initial begin
        #2000000;
        $display("vote_aggregator_unit: mismatch");
        $finish;
    end

endmodule

// File: vote_aggregator_unit.f
rtl/vagg_pkg.sv
rtl/vagg_ctrl.sv
rtl/vagg_dp.sv
rtl/vote_aggregator_unit.sv
test/tb_top.sv
